### rtl/lbm_pkg.sv
package lbm_pkg;

    // number format and grid geometry
    localparam int DIST_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int NUM_BITS  = DIST_BITS + FRAC_BITS;
    localparam int DCNT_BITS = $clog2(NUM_BITS + 1);
    localparam int ACC_BITS  = DIST_BITS + 4;
    localparam int SAT_BITS  = 42;
    localparam int NDIR      = 9;
    localparam int XBITS     = 6;
    localparam int YBITS     = 6;
    localparam int QBITS     = 4;
    localparam int GBITS     = 7;
    localparam int ADDR_BITS = QBITS + YBITS + XBITS;
    localparam int MAX_W     = 1 << XBITS;
    localparam int MAX_H     = 1 << YBITS;
    localparam int DEPTH     = NDIR * MAX_W * MAX_H;
    localparam int CFG_BITS  = 26;

    typedef logic signed [DIST_BITS-1:0] dist_t;

    localparam dist_t ONE    = 32'sd16777216;
    localparam dist_t VMAX   = 32'sh7fffffff;
    localparam dist_t VMIN   = 32'sh80000000;
    localparam dist_t W_REST = dist_t'(((64'sd8 << FRAC_BITS) + 64'sd9) / 64'sd18);
    localparam dist_t W_AXIS = dist_t'(((64'sd2 << FRAC_BITS) + 64'sd9) / 64'sd18);
    localparam dist_t W_DIAG = dist_t'(((64'sd2 << FRAC_BITS) + 64'sd36) / 64'sd72);

    localparam logic signed [SAT_BITS-1:0] SAT_HI = 42'sd2147483647;
    localparam logic signed [SAT_BITS-1:0] SAT_LO = -42'sd2147483648;
    localparam logic [NUM_BITS-1:0] LIM_POS = 56'h0000007fffffff;
    localparam logic [NUM_BITS-1:0] LIM_NEG = 56'h00000080000000;

    // input function codes
    localparam logic [1:0] FN_INIT  = 2'd0;
    localparam logic [1:0] FN_STEP  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;
    localparam logic [1:0] FN_SPARE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RELAX_RATE  = 2'd2;
    localparam logic [1:0] CFG_LID_SPEED   = 2'd3;

    localparam logic [QBITS-1:0] LAST_DIR = 4'd8;

    typedef struct packed {
        logic  o;
        dist_t v;
    } satr_t;

    // request to a shared unit
    typedef struct packed {
        logic  start;
        dist_t a;
        dist_t b;
    } ureq_t;

    // response from a shared unit
    typedef struct packed {
        logic  done;
        logic  over;
        dist_t r;
    } ures_t;

    function automatic satr_t sat42(input logic signed [SAT_BITS-1:0] v);
        satr_t s;
        if (v > SAT_HI)
        begin
            s.o = 1'b1;
            s.v = VMAX;
        end
        else if (v < SAT_LO)
        begin
            s.o = 1'b1;
            s.v = VMIN;
        end
        else
        begin
            s.o = 1'b0;
            s.v = dist_t'(v);
        end
        return s;
    endfunction

    function automatic dist_t dir_wt(input logic [QBITS-1:0] q);
        dist_t w;
        case (q)
            4'd0:                   w = W_REST;
            4'd1, 4'd2, 4'd3, 4'd4: w = W_AXIS;
            4'd5, 4'd6, 4'd7, 4'd8: w = W_DIAG;
            default:                w = '0;
        endcase
        return w;
    endfunction

    function automatic logic signed [1:0] dir_dx(input logic [QBITS-1:0] q);
        logic signed [1:0] d;
        case (q)
            4'd1, 4'd5, 4'd8: d = 2'sd1;
            4'd3, 4'd6, 4'd7: d = -2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [QBITS-1:0] q);
        logic signed [1:0] d;
        case (q)
            4'd2, 4'd5, 4'd6: d = 2'sd1;
            4'd4, 4'd7, 4'd8: d = -2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic [QBITS-1:0] dir_back(input logic [QBITS-1:0] q);
        logic [QBITS-1:0] b;
        case (q)
            4'd1:    b = 4'd3;
            4'd2:    b = 4'd4;
            4'd3:    b = 4'd1;
            4'd4:    b = 4'd2;
            4'd5:    b = 4'd7;
            4'd6:    b = 4'd8;
            4'd7:    b = 4'd5;
            4'd8:    b = 4'd6;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/lbm_ram.sv
module lbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lbm_mul.sv
module lbm_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  lbm_pkg::ureq_t req,
    output lbm_pkg::ures_t rsp
);

    logic                                v1_reg;
    logic                                neg1_reg;
    logic [2*lbm_pkg::DIST_BITS-1:0]     prod_reg;
    logic                                done_reg;
    logic                                over_reg;
    lbm_pkg::dist_t                      r_reg;

    logic [lbm_pkg::DIST_BITS-1:0]       ua;
    logic [lbm_pkg::DIST_BITS-1:0]       ub;
    logic [lbm_pkg::NUM_BITS-1:0]        rlo;
    logic [lbm_pkg::NUM_BITS-1:0]        lim;
    logic                                over;
    lbm_pkg::dist_t                      r;

    // form magnitudes
    always_comb
    begin
        ua = req.a;
        ub = req.b;
        if (req.a[lbm_pkg::DIST_BITS-1])
        begin
            ua = ~ua + 32'd1;
        end
        if (req.b[lbm_pkg::DIST_BITS-1])
        begin
            ub = ~ub + 32'd1;
        end
    end

    // drop fraction bits and saturate
    always_comb
    begin
        rlo  = {16'b0, prod_reg[2*lbm_pkg::DIST_BITS-1:lbm_pkg::FRAC_BITS]};
        lim  = neg1_reg ? lbm_pkg::LIM_NEG : lbm_pkg::LIM_POS;
        over = rlo > lim;
        if (over)
        begin
            r = neg1_reg ? lbm_pkg::VMIN : lbm_pkg::VMAX;
        end
        else if (neg1_reg)
        begin
            r = lbm_pkg::dist_t'(~rlo[lbm_pkg::DIST_BITS-1:0] + 32'd1);
        end
        else
        begin
            r = lbm_pkg::dist_t'(rlo[lbm_pkg::DIST_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= ua * ub;
            neg1_reg <= req.a[lbm_pkg::DIST_BITS-1] ^ req.b[lbm_pkg::DIST_BITS-1];
        end
        if (v1_reg)
        begin
            r_reg    <= r;
            over_reg <= over;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.over = over_reg;
    assign rsp.r    = r_reg;

endmodule

### rtl/lbm_div.sv
module lbm_div (
    input  logic          clk,
    input  logic          rst_n,
    input  lbm_pkg::ureq_t req,
    output lbm_pkg::ures_t rsp
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [lbm_pkg::DCNT_BITS-1:0]     cnt_reg;
    logic [lbm_pkg::DCNT_BITS-1:0]     cnt_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic [lbm_pkg::DIST_BITS-1:0]     d_reg;
    logic [lbm_pkg::DIST_BITS-1:0]     d_next;
    logic [lbm_pkg::DIST_BITS-1:0]     rem_reg;
    logic [lbm_pkg::DIST_BITS-1:0]     rem_next;
    logic [lbm_pkg::NUM_BITS-1:0]      num_reg;
    logic [lbm_pkg::NUM_BITS-1:0]      num_next;
    lbm_pkg::dist_t                    r_reg;
    lbm_pkg::dist_t                    r_next;
    logic                              over_reg;
    logic                              over_next;

    logic [lbm_pkg::DIST_BITS-1:0]     nu;
    logic [lbm_pkg::DIST_BITS:0]       trial;
    logic [lbm_pkg::DIST_BITS:0]       diff;
    logic                              ge;
    logic [lbm_pkg::NUM_BITS-1:0]      lim;

    always_comb
    begin
        nu    = req.a;
        if (nu[lbm_pkg::DIST_BITS-1])
        begin
            nu = ~nu + 32'd1;
        end
        trial = {rem_reg, num_reg[lbm_pkg::NUM_BITS-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = trial >= {1'b0, d_reg};
        lim   = neg_reg ? lbm_pkg::LIM_NEG : lbm_pkg::LIM_POS;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        r_next    = r_reg;
        over_next = over_reg;

        if (req.start)
        begin
            // load numerator magnitude shifted up by the fraction bits
            busy_next = 1'b1;
            cnt_next  = lbm_pkg::DCNT_BITS'(lbm_pkg::NUM_BITS);
            neg_next  = req.a[lbm_pkg::DIST_BITS-1];
            d_next    = req.b;
            rem_next  = '0;
            num_next  = {nu, {lbm_pkg::FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // one restoring step: quotient bit shifts in at the bottom
                rem_next = ge ? diff[lbm_pkg::DIST_BITS-1:0]
                              : trial[lbm_pkg::DIST_BITS-1:0];
                num_next = {num_reg[lbm_pkg::NUM_BITS-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                // saturate the quotient to the signed range
                busy_next = 1'b0;
                done_next = 1'b1;
                over_next = num_reg > lim;
                if (num_reg > lim)
                begin
                    r_next = neg_reg ? lbm_pkg::VMIN : lbm_pkg::VMAX;
                end
                else if (neg_reg)
                begin
                    r_next = lbm_pkg::dist_t'(~num_reg[lbm_pkg::DIST_BITS-1:0] + 32'd1);
                end
                else
                begin
                    r_next = lbm_pkg::dist_t'(num_reg[lbm_pkg::DIST_BITS-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        r_reg    <= r_next;
        over_reg <= over_next;
    end

    assign rsp.done = done_reg;
    assign rsp.over = over_reg;
    assign rsp.r    = r_reg;

endmodule

### rtl/lattice_boltzmann_d2q9_step.sv
// D2Q9 lattice Boltzmann engine with BGK collision and a moving lid.
// Input channel (in_valid / in_stall) carries one command word: func, cell_x,
// cell_y, direction. Output channel (out_valid / out_stall) returns one word
// per command: population_value and overflow_seen.
// The block takes one command at a time; in_stall stays high until the
// result word is loaded into the output register. A new command may be
// accepted while that word still waits for the receiver.
// func=0 init sweeps all 36864 words of the lattice memory. func=1 step
// walks all 64x64 cells; each cell inside the grid uses the bit-serial
// divider (two per cell) and the shared multiplier (four or five per
// population, five where it bounces off the lid in the top row); cells
// outside the grid use neither.
// The two lattice memories swap roles after each step.
// Reset clears control state and restores the register defaults. The lattice
// reads as all zero after reset until the first init or step; no clearing
// pass is run. While out_stall is high the result word holds and the next
// command finishes its work, then waits for the output register to free.
// Configuration writes (cfg_we) take effect at once; issue them when idle.
module lattice_boltzmann_d2q9_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [5:0]                      cell_x,
    input  logic [5:0]                      cell_y,
    input  logic [3:0]                      direction,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              population_value,
    output logic                            overflow_seen,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [lbm_pkg::CFG_BITS-1:0]    cfg_data
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_INIT  = 16'h0002,
        S_CELL  = 16'h0004,
        S_ZERO  = 16'h0008,
        S_RDA   = 16'h0010,
        S_RDD   = 16'h0020,
        S_SUMS  = 16'h0040,
        S_DIVGO = 16'h0080,
        S_DIVW  = 16'h0100,
        S_MULGO = 16'h0200,
        S_MULW  = 16'h0400,
        S_EU    = 16'h0800,
        S_WR    = 16'h1000,
        S_PRDA  = 16'h2000,
        S_PRDD  = 16'h4000,
        S_FIN   = 16'h8000
    } state_t;

    typedef enum logic [2:0] {
        MOP_UXX = 3'd0,
        MOP_UYY = 3'd1,
        MOP_EU2 = 3'd2,
        MOP_RW  = 3'd3,
        MOP_FEQ = 3'd4,
        MOP_OMG = 3'd5,
        MOP_LID = 3'd6
    } mop_t;

    localparam int XB = lbm_pkg::XBITS;
    localparam int YB = lbm_pkg::YBITS;
    localparam int QB = lbm_pkg::QBITS;
    localparam int AB = lbm_pkg::ADDR_BITS;
    localparam int GB = lbm_pkg::GBITS;

    // configuration
    logic [GB-1:0]               grid_width_reg;
    logic [GB-1:0]               grid_height_reg;
    logic [25:0]                 relax_rate_reg;
    logic [24:0]                 lid_speed_reg;

    // control
    state_t                      state_reg, state_next;
    logic                        sel_reg, sel_next;
    logic                        blank_reg, blank_next;
    logic                        flag_reg, flag_next;
    logic                        out_valid_reg, out_valid_next;

    // datapath
    mop_t                        mop_reg, mop_next;
    logic                        comp_reg, comp_next;
    logic [AB-1:0]               cnt_reg, cnt_next;
    logic [XB-1:0]               x_reg, x_next;
    logic [YB-1:0]               y_reg, y_next;
    logic [QB-1:0]               q_reg, q_next;
    logic [XB-1:0]               pcx_reg, pcx_next;
    logic [YB-1:0]               pcy_reg, pcy_next;
    logic [QB-1:0]               pdir_reg, pdir_next;
    lbm_pkg::dist_t              f_reg [lbm_pkg::NDIR];
    lbm_pkg::dist_t              f_next [lbm_pkg::NDIR];
    logic signed [lbm_pkg::ACC_BITS-1:0] rho_acc_reg, rho_acc_next;
    logic signed [lbm_pkg::ACC_BITS-1:0] mx_acc_reg, mx_acc_next;
    logic signed [lbm_pkg::ACC_BITS-1:0] my_acc_reg, my_acc_next;
    lbm_pkg::dist_t              rho_reg, rho_next;
    lbm_pkg::dist_t              mx_reg, mx_next;
    lbm_pkg::dist_t              my_reg, my_next;
    lbm_pkg::dist_t              ux_reg, ux_next;
    lbm_pkg::dist_t              uy_reg, uy_next;
    lbm_pkg::dist_t              p_reg, p_next;
    logic signed [33:0]          tusq_reg, tusq_next;
    lbm_pkg::dist_t              eu_reg, eu_next;
    logic signed [37:0]          pa_reg, pa_next;
    lbm_pkg::dist_t              poly_reg, poly_next;
    lbm_pkg::dist_t              rw_reg, rw_next;
    lbm_pkg::dist_t              dif_reg, dif_next;
    lbm_pkg::dist_t              fc_reg, fc_next;
    lbm_pkg::dist_t              val_reg, val_next;
    lbm_pkg::dist_t              pop_out_reg, pop_out_next;
    logic                        ovf_out_reg, ovf_out_next;

    // shared units and memory ports
    lbm_pkg::ureq_t              mreq;
    lbm_pkg::ures_t              mrsp;
    lbm_pkg::ureq_t              dreq;
    lbm_pkg::ures_t              drsp;
    logic                        mem_we;
    logic                        mem_bank;
    logic [AB-1:0]               mem_waddr;
    lbm_pkg::dist_t              mem_wdata;
    logic [AB-1:0]               mem_raddr;
    logic [31:0]                 rdata0;
    logic [31:0]                 rdata1;

    // combinational helpers
    logic [GB-1:0]               w_eff;
    logic [GB-1:0]               h_eff;
    logic signed [1:0]           dx_q;
    logic signed [1:0]           dy_q;
    logic signed [7:0]           tx;
    logic signed [7:0]           ty;
    logic                        outside;
    logic                        lid_hit;
    logic                        cell_in;
    logic                        init_in;
    logic                        last_cell;
    logic [AB-1:0]               dest_addr;
    lbm_pkg::dist_t              rd;
    lbm_pkg::dist_t              fq;
    lbm_pkg::dist_t              omega;
    lbm_pkg::dist_t              lid;
    logic signed [33:0]          eux;
    logic signed [33:0]          euy;
    lbm_pkg::satr_t              sa, sb, sc;

    // clamp grid size to the array
    assign w_eff = (grid_width_reg > GB'(lbm_pkg::MAX_W)) ? GB'(lbm_pkg::MAX_W)
                                                          : grid_width_reg;
    assign h_eff = (grid_height_reg > GB'(lbm_pkg::MAX_H)) ? GB'(lbm_pkg::MAX_H)
                                                           : grid_height_reg;

    // neighbor and wall tests for the current population
    assign dx_q    = lbm_pkg::dir_dx(q_reg);
    assign dy_q    = lbm_pkg::dir_dy(q_reg);
    assign tx      = $signed({2'b00, x_reg}) + $signed({{6{dx_q[1]}}, dx_q});
    assign ty      = $signed({2'b00, y_reg}) + $signed({{6{dy_q[1]}}, dy_q});
    assign lid_hit = ty >= $signed({1'b0, h_eff});
    assign outside = tx[7] || ty[7] || (tx >= $signed({1'b0, w_eff})) || lid_hit;
    assign dest_addr = outside ? {lbm_pkg::dir_back(q_reg), y_reg, x_reg}
                               : {q_reg, ty[YB-1:0], tx[XB-1:0]};
    assign cell_in = ({1'b0, x_reg} < w_eff) && ({1'b0, y_reg} < h_eff);
    assign init_in = ({1'b0, cnt_reg[XB-1:0]} < w_eff)
                  && ({1'b0, cnt_reg[XB+YB-1:XB]} < h_eff);
    assign last_cell = (x_reg == '1) && (y_reg == '1);

    assign rd    = blank_reg ? '0 : lbm_pkg::dist_t'(sel_reg ? rdata1 : rdata0);
    assign fq    = f_reg[q_reg];
    assign omega = lbm_pkg::dist_t'({6'b0, relax_rate_reg});
    assign lid   = lbm_pkg::dist_t'({{7{lid_speed_reg[24]}}, lid_speed_reg});

    // velocity projection onto the current direction
    always_comb
    begin
        case (dx_q)
            2'sd1:   eux = 34'(ux_reg);
            -2'sd1:  eux = -34'(ux_reg);
            default: eux = '0;
        endcase
        case (dy_q)
            2'sd1:   euy = 34'(uy_reg);
            -2'sd1:  euy = -34'(uy_reg);
            default: euy = '0;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mreq.start = (state_reg == S_MULGO);
        case (mop_reg)
            MOP_UXX:
            begin
                mreq.a = ux_reg;
                mreq.b = ux_reg;
            end
            MOP_UYY:
            begin
                mreq.a = uy_reg;
                mreq.b = uy_reg;
            end
            MOP_EU2:
            begin
                mreq.a = eu_reg;
                mreq.b = eu_reg;
            end
            MOP_RW:
            begin
                mreq.a = rho_reg;
                mreq.b = lbm_pkg::dir_wt(q_reg);
            end
            MOP_FEQ:
            begin
                mreq.a = rw_reg;
                mreq.b = poly_reg;
            end
            MOP_OMG:
            begin
                mreq.a = omega;
                mreq.b = dif_reg;
            end
            MOP_LID:
            begin
                mreq.a = rw_reg;
                mreq.b = lid;
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // divider operands
    assign dreq.start = (state_reg == S_DIVGO);
    assign dreq.a     = comp_reg ? my_reg : mx_reg;
    assign dreq.b     = rho_reg;

    // memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_bank  = ~sel_reg;
        mem_waddr = dest_addr;
        mem_wdata = fc_reg;
        mem_raddr = {q_reg, y_reg, x_reg};
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_bank  = sel_reg;
                mem_waddr = cnt_reg;
                mem_wdata = init_in ? lbm_pkg::dir_wt(cnt_reg[AB-1:XB+YB]) : '0;
            end
            S_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = {q_reg, y_reg, x_reg};
                mem_wdata = '0;
            end
            S_WR:
            begin
                mem_we = 1'b1;
            end
            S_PRDA:
            begin
                mem_raddr = {pdir_reg, pcy_reg, pcx_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        blank_next     = blank_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        mop_next       = mop_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        pcx_next       = pcx_reg;
        pcy_next       = pcy_reg;
        pdir_next      = pdir_reg;
        f_next         = f_reg;
        rho_acc_next   = rho_acc_reg;
        mx_acc_next    = mx_acc_reg;
        my_acc_next    = my_acc_reg;
        rho_next       = rho_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        p_next         = p_reg;
        tusq_next      = tusq_reg;
        eu_next        = eu_reg;
        pa_next        = pa_reg;
        poly_next      = poly_reg;
        rw_next        = rw_reg;
        dif_next       = dif_reg;
        fc_next        = fc_reg;
        val_next       = val_reg;
        pop_out_next   = pop_out_reg;
        ovf_out_next   = ovf_out_reg;
        sa             = '0;
        sb             = '0;
        sc             = '0;

        // release the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pcx_next  = cell_x;
                    pcy_next  = cell_y;
                    pdir_next = direction;
                    val_next  = '0;
                    case (func)
                        lbm_pkg::FN_INIT:
                        begin
                            cnt_next   = '0;
                            state_next = S_INIT;
                        end
                        lbm_pkg::FN_STEP:
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            state_next = S_CELL;
                        end
                        lbm_pkg::FN_READ:
                        begin
                            state_next = S_PRDA;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                // sweep the whole memory with direction weights inside the grid, zero outside
                if (cnt_reg == AB'(lbm_pkg::DEPTH - 1))
                begin
                    blank_next = 1'b0;
                    flag_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_CELL:
            begin
                q_next       = '0;
                rho_acc_next = '0;
                mx_acc_next  = '0;
                my_acc_next  = '0;
                state_next   = cell_in ? S_RDA : S_ZERO;
            end

            S_ZERO:
            begin
                if (q_reg == lbm_pkg::LAST_DIR)
                begin
                    if (last_cell)
                    begin
                        sel_next   = ~sel_reg;
                        blank_next = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        y_next     = (x_reg == '1) ? y_reg + 1'b1 : y_reg;
                        state_next = S_CELL;
                    end
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                end
            end

            S_RDA:
            begin
                state_next = S_RDD;
            end

            S_RDD:
            begin
                // hold the population and accumulate the moments
                f_next[q_reg] = rd;
                rho_acc_next  = rho_acc_reg + 36'(rd);
                if (dx_q == 2'sd1)
                begin
                    mx_acc_next = mx_acc_reg + 36'(rd);
                end
                else if (dx_q == -2'sd1)
                begin
                    mx_acc_next = mx_acc_reg - 36'(rd);
                end
                if (dy_q == 2'sd1)
                begin
                    my_acc_next = my_acc_reg + 36'(rd);
                end
                else if (dy_q == -2'sd1)
                begin
                    my_acc_next = my_acc_reg - 36'(rd);
                end
                if (q_reg == lbm_pkg::LAST_DIR)
                begin
                    state_next = S_SUMS;
                end
                else
                begin
                    q_next     = q_reg + 1'b1;
                    state_next = S_RDA;
                end
            end

            S_SUMS:
            begin
                sa        = lbm_pkg::sat42(42'(rho_acc_reg));
                sb        = lbm_pkg::sat42(42'(mx_acc_reg));
                sc        = lbm_pkg::sat42(42'(my_acc_reg));
                flag_next = flag_reg | sa.o | sb.o | sc.o;
                rho_next  = (sa.v <= 0) ? lbm_pkg::ONE : sa.v;
                mx_next   = sb.v;
                my_next   = sc.v;
                comp_next = 1'b0;
                state_next = S_DIVGO;
            end

            S_DIVGO:
            begin
                state_next = S_DIVW;
            end

            S_DIVW:
            begin
                if (drsp.done)
                begin
                    flag_next = flag_reg | drsp.over;
                    if (!comp_reg)
                    begin
                        ux_next    = drsp.r;
                        comp_next  = 1'b1;
                        state_next = S_DIVGO;
                    end
                    else
                    begin
                        uy_next    = drsp.r;
                        mop_next   = MOP_UXX;
                        state_next = S_MULGO;
                    end
                end
            end

            S_MULGO:
            begin
                state_next = S_MULW;
            end

            S_MULW:
            begin
                if (mrsp.done)
                begin
                    flag_next = flag_reg | mrsp.over;
                    case (mop_reg)
                        MOP_UXX:
                        begin
                            p_next     = mrsp.r;
                            mop_next   = MOP_UYY;
                            state_next = S_MULGO;
                        end
                        MOP_UYY:
                        begin
                            sa         = lbm_pkg::sat42(42'(p_reg) + 42'(mrsp.r));
                            flag_next  = flag_reg | mrsp.over | sa.o;
                            tusq_next  = (34'(sa.v) * 3) >>> 1;
                            q_next     = '0;
                            state_next = S_EU;
                        end
                        MOP_EU2:
                        begin
                            sa = lbm_pkg::sat42(42'(pa_reg) + ((42'(mrsp.r) * 9) >>> 1));
                            flag_next  = flag_reg | mrsp.over | sa.o;
                            poly_next  = sa.v;
                            mop_next   = MOP_RW;
                            state_next = S_MULGO;
                        end
                        MOP_RW:
                        begin
                            rw_next    = mrsp.r;
                            mop_next   = MOP_FEQ;
                            state_next = S_MULGO;
                        end
                        MOP_FEQ:
                        begin
                            sa         = lbm_pkg::sat42(42'(fq) - 42'(mrsp.r));
                            flag_next  = flag_reg | mrsp.over | sa.o;
                            dif_next   = sa.v;
                            mop_next   = MOP_OMG;
                            state_next = S_MULGO;
                        end
                        MOP_OMG:
                        begin
                            sa        = lbm_pkg::sat42(42'(fq) - 42'(mrsp.r));
                            flag_next = flag_reg | mrsp.over | sa.o;
                            fc_next   = sa.v;
                            if (outside && lid_hit)
                            begin
                                mop_next   = MOP_LID;
                                state_next = S_MULGO;
                            end
                            else
                            begin
                                state_next = S_WR;
                            end
                        end
                        MOP_LID:
                        begin
                            // lid momentum correction on the bounced word
                            if (dx_q == 2'sd1)
                            begin
                                sb = lbm_pkg::sat42(42'(mrsp.r) * 6);
                            end
                            else if (dx_q == -2'sd1)
                            begin
                                sb = lbm_pkg::sat42(-(42'(mrsp.r) * 6));
                            end
                            else
                            begin
                                sb = '0;
                            end
                            sc         = lbm_pkg::sat42(42'(fc_reg) - 42'(sb.v));
                            flag_next  = flag_reg | mrsp.over | sb.o | sc.o;
                            fc_next    = sc.v;
                            state_next = S_WR;
                        end
                        default:
                        begin
                            state_next = S_WR;
                        end
                    endcase
                end
            end

            S_EU:
            begin
                sa         = lbm_pkg::sat42(42'(eux) + 42'(euy));
                flag_next  = flag_reg | sa.o;
                eu_next    = sa.v;
                pa_next    = 38'(lbm_pkg::ONE) + 38'(sa.v) * 3 - 38'(tusq_reg);
                mop_next   = MOP_EU2;
                state_next = S_MULGO;
            end

            S_WR:
            begin
                if (q_reg == lbm_pkg::LAST_DIR)
                begin
                    if (last_cell)
                    begin
                        sel_next   = ~sel_reg;
                        blank_next = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        y_next     = (x_reg == '1) ? y_reg + 1'b1 : y_reg;
                        state_next = S_CELL;
                    end
                end
                else
                begin
                    q_next     = q_reg + 1'b1;
                    state_next = S_EU;
                end
            end

            S_PRDA:
            begin
                state_next = (pdir_reg > lbm_pkg::LAST_DIR) ? S_FIN : S_PRDD;
            end

            S_PRDD:
            begin
                val_next   = rd;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // load the result word when the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pop_out_next   = val_reg;
                    ovf_out_next   = flag_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
            relax_rate_reg  <= 26'd16777216;
            lid_speed_reg   <= 25'd1677722;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbm_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GB-1:0];
                lbm_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[GB-1:0];
                lbm_pkg::CFG_RELAX_RATE:  relax_rate_reg  <= cfg_data;
                lbm_pkg::CFG_LID_SPEED:   lid_speed_reg   <= cfg_data[24:0];
                default:                  grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            blank_reg     <= 1'b1;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            blank_reg     <= blank_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mop_reg     <= mop_next;
        comp_reg    <= comp_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        q_reg       <= q_next;
        pcx_reg     <= pcx_next;
        pcy_reg     <= pcy_next;
        pdir_reg    <= pdir_next;
        f_reg       <= f_next;
        rho_acc_reg <= rho_acc_next;
        mx_acc_reg  <= mx_acc_next;
        my_acc_reg  <= my_acc_next;
        rho_reg     <= rho_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        p_reg       <= p_next;
        tusq_reg    <= tusq_next;
        eu_reg      <= eu_next;
        pa_reg      <= pa_next;
        poly_reg    <= poly_next;
        rw_reg      <= rw_next;
        dif_reg     <= dif_next;
        fc_reg      <= fc_next;
        val_reg     <= val_next;
        pop_out_reg <= pop_out_next;
        ovf_out_reg <= ovf_out_next;
    end

    lbm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    lbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    lbm_ram #(
        .WIDTH (lbm_pkg::DIST_BITS),
        .DEPTH (lbm_pkg::DEPTH)
    ) u_ram0 (
        .clk   (clk),
        .we    (mem_we && !mem_bank),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata0)
    );

    lbm_ram #(
        .WIDTH (lbm_pkg::DIST_BITS),
        .DEPTH (lbm_pkg::DEPTH)
    ) u_ram1 (
        .clk   (clk),
        .we    (mem_we && mem_bank),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata1)
    );

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign population_value = pop_out_reg;
    assign overflow_seen    = ovf_out_reg;

endmodule

### rtl/lbm_check.sv
module lbm_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [31:0]           population_value,
    input logic                         overflow_seen
);

    // a command keeps the block busy after it is taken
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("block not busy after accepting a command");

    // a stalled result word holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(population_value) && $stable(overflow_seen))
    ) else $error("stalled result word changed");

    // a new result word appears only at the end of a busy command
    a_out_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result word without a command in progress");

endmodule

bind lattice_boltzmann_d2q9_step lbm_check u_check (.*);
